### rtl/oaht_pkg.sv
// Shared types, constants and functions for the open addressing hash table.
package oaht_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned CfgW = 11;
  localparam logic [CfgW-1:0] MaxUsedReset = 11'd768;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] KK_BOOL = 2'd0;
  localparam logic [1:0] KK_NUM = 2'd1;
  localparam logic [1:0] KK_STR = 2'd2;
  localparam logic [1:0] KK_OBJ = 2'd3;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED = 2'd1;
  localparam logic [1:0] ST_TOMB = 2'd2;

  localparam logic [1:0] RS_DONE = 2'd0;
  localparam logic [1:0] RS_REFUSED = 2'd1;
  localparam logic [1:0] RS_EXHAUST = 2'd2;

  localparam logic [63:0] MagMask = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ExpMask = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] ManMask = 64'h000F_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  key_kind;
    logic [63:0] key;
    logic [1:0]  value_kind;
    logic [63:0] value;
  } slot_t;

  function automatic logic is_nan(input logic [63:0] b);
    return ((b & ExpMask) == ExpMask) && ((b & ManMask) != 64'd0);
  endfunction

  function automatic logic key_match(input slot_t s, input logic [1:0] kind,
                                     input logic [63:0] bits);
    logic r;
    r = (s.key_kind == kind) && (s.key == bits);
    if (s.key_kind == kind && kind == KK_NUM) begin
      if (is_nan(s.key) || is_nan(bits)) r = 1'b0;
      else if ((s.key & MagMask) == 64'd0 && (bits & MagMask) == 64'd0) r = 1'b1;
    end
    return r;
  endfunction

endpackage

### rtl/oaht_if.sv
// Valid/ready channel interfaces for requests and results.
interface oaht_req_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  key_kind;
  logic [63:0] key_bits;
  logic [31:0] key_string_hash;
  logic [1:0]  value_kind;
  logic [63:0] value_bits;
  modport source (output valid, opcode, key_kind, key_bits, key_string_hash,
                  value_kind, value_bits, input ready);
  modport sink (input valid, opcode, key_kind, key_bits, key_string_hash,
                value_kind, value_bits, output ready);
endinterface

interface oaht_rsp_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  out_value_kind;
  logic [63:0] out_value_bits;
  logic [1:0]  status;
  modport source (output valid, hit, out_value_kind, out_value_bits, status,
                  input ready);
  modport sink (input valid, hit, out_value_kind, out_value_bits, status,
                output ready);
endinterface

### rtl/oaht_hash.sv
// Home slot computation: registered hash of the request key.
module oaht_hash (
  input  logic                      clk,
  input  logic [1:0]                key_kind,
  input  logic [63:0]               key_bits,
  input  logic [31:0]               key_string_hash,
  output logic [oaht_pkg::IdxW-1:0] home
);
  logic [63:0] b0, b1, mid, c0, c1;
  logic [31:0] h;

  // first half of the mix, registered
  always_comb begin
    b0 = ((key_bits & oaht_pkg::MagMask) == 64'd0) ? 64'd0 : key_bits;
    b1 = b0 + ~(b0 << 32);
    b1 = b1 ^ (b1 >> 22);
    b1 = b1 + ~(b1 << 13);
    b1 = b1 ^ (b1 >> 8);
  end

  always_ff @(posedge clk) begin
    mid <= b1;
  end

  always_comb begin
    c0 = mid + (mid << 3);
    c0 = c0 ^ (c0 >> 15);
    c1 = c0 + ~(c0 << 27);
    c1 = c1 ^ (c1 >> 31);
  end

  logic [1:0]  kind_q;
  logic [63:0] bits_q;
  logic [31:0] shash_q;
  always_ff @(posedge clk) begin
    kind_q  <= key_kind;
    bits_q  <= key_bits;
    shash_q <= key_string_hash;
  end

  always_comb begin
    case (kind_q)
      oaht_pkg::KK_BOOL: h = {31'd0, bits_q[0]};
      oaht_pkg::KK_NUM:  h = c1[31:0];
      oaht_pkg::KK_STR:  h = shash_q;
      default:           h = bits_q[31:0];
    endcase
  end

  assign home = h[oaht_pkg::IdxW-1:0];
endmodule

### rtl/oaht_slot_ram.sv
// Slot memory: one write port, one read port, registered read data.
module oaht_slot_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [oaht_pkg::IdxW-1:0] waddr,
  input  oaht_pkg::slot_t           wdata,
  input  logic [oaht_pkg::IdxW-1:0] raddr,
  output oaht_pkg::slot_t           rdata
);
  oaht_pkg::slot_t mem [oaht_pkg::Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/open_addressing_hash_table.sv
// Top level of the open addressing hash table: probe sequencer and config.
//
//  channel  dir  protocol   payload
//  req      in   valid/rdy  opcode, key_kind, key_bits, key_string_hash, value_*
//  rsp      out  valid/rdy  hit, out_value_kind, out_value_bits, status
//  apb      in   APB write  max_used_slots at address 0
//
// After acceptance a request passes a hash state, a state that loads the home
// slot index, then a read and a decision state for each slot probed (the home
// slot and up to Capacity - 1 beyond it), a result state and then idle; an
// OP_NONE request goes from idle straight to the result state. After reset a
// clearing pass empties all Capacity slots of the slot memory; no request is
// taken meanwhile. A result held by a stalled sink blocks the next request until it is taken.
module open_addressing_hash_table (
  input  logic          clk,
  input  logic          rst,
  oaht_req_if.sink      req,
  oaht_rsp_if.source    rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  localparam int unsigned IdxW = oaht_pkg::IdxW;
  localparam int unsigned CntW = oaht_pkg::CntW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  // read of the slot at idx in flight; data valid in the following S_PROBE
  localparam logic [2:0] S_READ_NEXT = 3'd6;

  logic [2:0] state;
  logic [oaht_pkg::CfgW-1:0] max_used_slots;
  logic [CntW-1:0] used_count;

  // request register
  logic [1:0]  op, kind, vkind;
  logic [63:0] kbits, vbits;
  logic [31:0] shash;

  logic [IdxW-1:0] home, idx, tomb;
  logic [CntW-1:0] n;
  logic            have_tomb;
  logic [IdxW-1:0] clr;

  logic            we;
  logic [IdxW-1:0] waddr;
  oaht_pkg::slot_t wdata, rdata;

  logic            r_hit;
  logic [1:0]      r_vk, r_st;
  logic [63:0]     r_vb;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {21'd0, max_used_slots} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) max_used_slots <= oaht_pkg::MaxUsedReset;
    else if (psel && penable && pwrite && paddr == 1'b0)
      max_used_slots <= pwdata[oaht_pkg::CfgW-1:0];
  end

  oaht_hash u_hash (
    .clk(clk), .key_kind(kind), .key_bits(kbits), .key_string_hash(shash),
    .home(home)
  );

  oaht_slot_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.hit = r_hit;
  assign rsp.out_value_kind = r_vk;
  assign rsp.out_value_bits = r_vb;
  assign rsp.status = r_st;

  logic match, last;
  always_comb begin
    match = (rdata.status == oaht_pkg::ST_USED) && oaht_pkg::key_match(rdata, kind, kbits);
    last  = (n == CntW'(oaht_pkg::Capacity - 1));
  end

  // decision for the slot just read
  logic            done;
  logic            d_we;
  logic [IdxW-1:0] d_addr;
  oaht_pkg::slot_t d_data;
  logic            d_hit, d_cnt;
  logic [1:0]      d_st, d_vk;
  logic [63:0]     d_vb;
  always_comb begin
    done = 1'b1; d_we = 1'b0; d_addr = idx; d_hit = 1'b0; d_cnt = 1'b0;
    d_st = oaht_pkg::RS_DONE; d_vk = 2'd0; d_vb = 64'd0;
    d_data = '{status: oaht_pkg::ST_USED, key_kind: kind, key: kbits,
               value_kind: vkind, value: vbits};
    if (match) begin
      d_hit = (op != oaht_pkg::OP_SET);
      case (op)
        oaht_pkg::OP_GET: begin d_vk = rdata.value_kind; d_vb = rdata.value; end
        oaht_pkg::OP_DEL: begin
          d_we = 1'b1; d_data = rdata; d_data.status = oaht_pkg::ST_TOMB;
        end
        default: d_we = 1'b1;
      endcase
    end else if (rdata.status == oaht_pkg::ST_EMPTY || last) begin
      if (op != oaht_pkg::OP_SET) begin
        if (rdata.status != oaht_pkg::ST_EMPTY) d_st = oaht_pkg::RS_EXHAUST;
      end else if (have_tomb || (rdata.status == oaht_pkg::ST_TOMB)) begin
        d_we = 1'b1; d_hit = 1'b1;
        d_addr = have_tomb ? tomb : idx;
      end else if (rdata.status == oaht_pkg::ST_EMPTY) begin
        if ({1'b0, used_count} + 12'd1 > {1'b0, max_used_slots}) begin
          d_st = oaht_pkg::RS_REFUSED;
        end else begin
          d_we = 1'b1; d_hit = 1'b1; d_cnt = 1'b1;
        end
      end else begin
        d_st = oaht_pkg::RS_EXHAUST;
      end
    end else begin
      done = 1'b0;
    end
  end

  always_comb begin
    we = 1'b0; waddr = d_addr; wdata = d_data;
    if (state == S_CLEAR) begin
      we = 1'b1; waddr = clr; wdata = '0;
    end else if (state == S_PROBE && done) begin
      we = d_we;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; used_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IdxW'(oaht_pkg::Capacity - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          op <= req.opcode; kind <= req.key_kind; vkind <= req.value_kind;
          vbits <= req.value_bits; shash <= req.key_string_hash;
          kbits <= (req.key_kind == oaht_pkg::KK_BOOL) ?
                   {63'd0, req.key_bits[0]} : req.key_bits;
          if (req.opcode == oaht_pkg::OP_NONE) begin
            r_hit <= 1'b0; r_vk <= 2'd0; r_vb <= 64'd0; r_st <= oaht_pkg::RS_DONE;
            state <= S_OUT;
          end else begin
            state <= S_HASH;
          end
        end
        S_HASH: state <= S_READ;
        S_READ: begin
          idx <= home; n <= '0; have_tomb <= 1'b0; state <= S_READ_NEXT;
        end
        S_READ_NEXT: state <= S_PROBE;
        S_PROBE: begin
          if (done) begin
            r_hit <= d_hit; r_vk <= d_vk; r_vb <= d_vb; r_st <= d_st;
            if (d_cnt) used_count <= used_count + 1'b1;
            state <= S_OUT;
          end else begin
            if (rdata.status == oaht_pkg::ST_TOMB && !have_tomb) begin
              have_tomb <= 1'b1; tomb <= idx;
            end
            idx <= idx + 1'b1; n <= n + 1'b1;
            state <= S_READ_NEXT;
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready) else $error("ready during clear");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    $rose(used_count[0]) || $fell(used_count[0]) |-> $past(state) == S_PROBE)
    else $error("count changed outside probe");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> n < CntW'(oaht_pkg::Capacity)) else $error("probe overrun");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_CLEAR || state == S_PROBE) else $error("stray write");
`endif
endmodule
